// ===== hdl/pcrms_pkg.sv =====
// Package with shared types and constants for the per-cell running mean and std block.
`timescale 1ns / 1ps
package pcrms_pkg;

  localparam int unsigned NumCellsDefault = 1024;
  localparam int unsigned CountW = 24;
  localparam int unsigned DataW  = 32;
  localparam int unsigned M2W    = 64;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_RSVD  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CNT_SAT = 2'd1,
    ST_M2_SAT  = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]        func;
    logic [9:0]        cell_index;
    logic [DataW-1:0]  sample_value;
    logic              last_sample;
  } in_item_t;

  typedef struct packed {
    logic [CountW-1:0] cell_count;
    logic [DataW-1:0]  cell_mean;
    logic [DataW-1:0]  cell_std;
    logic [1:0]        status;
    logic              last_result;
  } out_item_t;

  // Command from the sequencer to the divide/root unit.
  typedef struct packed {
    logic start;
    logic is_root;
  } du_cmd_t;

endpackage

// ===== hdl/pcrms_if.sv =====
// Valid/ready channel interfaces for the input and result items.
`timescale 1ns / 1ps
interface pcrms_in_if;
  import pcrms_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pcrms_out_if;
  import pcrms_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/pcrms_divsqrt.sv =====
// Shared radix-2 unit: 64 by 64 unsigned divide, or 64-bit integer square root.
`timescale 1ns / 1ps
module pcrms_divsqrt (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pcrms_pkg::du_cmd_t     cmd_i,
  input  logic [63:0]            num_i,
  input  logic [63:0]            den_i,
  output logic                   done_o,
  output logic [63:0]            res_o
);
  import pcrms_pkg::*;

  logic        busy_q, busy_d, root_q, root_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [63:0] x_q, x_d, r_q, r_d, d_q, d_d;
  logic [64:0] rem_q, rem_d;
  logic [64:0] trial;
  logic [65:0] rtrial;
  logic [65:0] rrem;

  always_comb begin
    busy_d = busy_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    x_d    = x_q;
    r_d    = r_q;
    d_d    = d_q;
    rem_d  = rem_q;
    trial  = '0;
    rtrial = '0;
    rrem   = '0;
    if (cmd_i.start) begin
      busy_d = 1'b1;
      root_d = cmd_i.is_root;
      x_d    = num_i;
      d_d    = den_i;
      r_d    = '0;
      rem_d  = '0;
      cnt_d  = cmd_i.is_root ? 7'd32 : 7'd64;
    end else if (busy_q) begin
      if (root_q) begin
        // Restoring square root: bring down two bits per step.
        rrem   = {rem_q[63:0], x_q[63:62]};
        rtrial = {r_q[63:0], 2'b01};
        x_d    = {x_q[61:0], 2'b00};
        if (rrem >= rtrial) begin
          rem_d = 65'(rrem - rtrial);
          r_d   = {r_q[62:0], 1'b1};
        end else begin
          rem_d = rrem[64:0];
          r_d   = {r_q[62:0], 1'b0};
        end
      end else begin
        trial = {rem_q[63:0], x_q[63]};
        x_d   = {x_q[62:0], 1'b0};
        if (trial >= {1'b0, d_q}) begin
          rem_d = trial - {1'b0, d_q};
          r_d   = {r_q[62:0], 1'b1};
        end else begin
          rem_d = trial;
          r_d   = {r_q[62:0], 1'b0};
        end
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
      end
    end
    res_o = r_q;
  end

  logic fin_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      root_q <= 1'b0;
      cnt_q  <= '0;
      fin_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      root_q <= root_d;
      cnt_q  <= cnt_d;
      fin_q  <= busy_q && (cnt_q == 7'd1) && !cmd_i.start;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    r_q   <= r_d;
    d_q   <= d_d;
    rem_q <= rem_d;
  end

  assign done_o = fin_q;

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_q)) else $error("done without busy");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |-> !busy_q) else $error("start while busy");
  a_cnt_zero_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q == 7'd1 && !cmd_i.start) |=> !busy_q) else $error("busy overrun");
`endif
endmodule

// ===== hdl/per_cell_running_mean_std.sv =====
// Top level: per-cell Welford mean and standard deviation with a cell table.
//
// Input channel in_if carries func, cell_index, sample_value and last_sample;
// result channel out_if carries cell_count, cell_mean, cell_std, status and
// last_result. A transaction on either side completes when valid and ready
// are both high. Every input transaction yields exactly one result.
// One item is handled at a time. An add runs a 64-step divide for the mean
// update, a 64-step divide of M2 by count-1 and a 32-step square root, all on
// one shared radix-2 divide/root unit, plus table read, multiply, accumulate,
// write and output states. Reads and clears skip the mean divide.
// Items with a count below two skip the M2 divide and the square root; an index
// beyond the table skips the table and returns a zero count, mean and std.
// A new input is taken from the cycle after the result has been delivered.
// After reset a clearing pass writes zero to every cell, one cell per cycle,
// during which no input is accepted.
// The result sits in an output register; while the receiver stalls it is
// held and no new input is taken until the result has been delivered.
`timescale 1ns / 1ps
module per_cell_running_mean_std #(
  parameter int unsigned NUM_CELLS = pcrms_pkg::NumCellsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  pcrms_in_if.sink     in_if,
  pcrms_out_if.source  out_if
);
  import pcrms_pkg::*;

  localparam int unsigned AW = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

  typedef enum logic [11:0] {
    S_CLR   = 12'b000000000001,
    S_IDLE  = 12'b000000000010,
    S_RD    = 12'b000000000100,
    S_LAT   = 12'b000000001000,
    S_DIV1  = 12'b000000010000,
    S_MUL   = 12'b000000100000,
    S_ACC   = 12'b000001000000,
    S_DIV2  = 12'b000010000000,
    S_ROOT  = 12'b000100000000,
    S_WB    = 12'b001000000000,
    S_OUT   = 12'b010000000000,
    S_WAITD = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  logic [M2W+CountW+DataW-1:0] mem [NUM_CELLS];
  logic                       we;
  logic [AW-1:0]              waddr;
  logic [AW-1:0]              cell_addr;
  logic [M2W+CountW+DataW-1:0] wdata, rdata_q;
  logic [AW:0]                clr_q, clr_d;

  in_item_t  item_q, item_d;
  out_item_t res_q, res_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [DataW-1:0]  mean_q, mean_d;
  logic [M2W-1:0]    m2_q, m2_d;
  logic [32:0]       dev_q, dev_d;
  logic [32:0]       e_q, e_d;
  logic [63:0]       prod_q, prod_d;
  logic              neg_q, neg_d;
  logic [1:0]        stat_q, stat_d;
  logic              wait_div_q, wait_div_d;

  du_cmd_t     du_cmd;
  logic [63:0] du_num, du_den, du_res;
  logic        du_done;

  pcrms_divsqrt u_du (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (du_cmd),
    .num_i  (du_num),
    .den_i  (du_den),
    .done_o (du_done),
    .res_o  (du_res)
  );

  logic in_range;
  logic [32:0] smp_ext, mean_ext, nmean;
  logic [32:0] absd;
  logic [32:0] abse;
  logic [64:0] sum;

  assign in_range  = ({7'd0, item_q.cell_index} < 17'(NUM_CELLS));
  assign cell_addr = AW'(item_q.cell_index);
  assign smp_ext   = {item_q.sample_value[31], item_q.sample_value};
  assign mean_ext  = {mean_q[31], mean_q};
  assign absd      = dev_q[32] ? 33'(-dev_q) : dev_q;
  // Both magnitudes stay below 2^32 since samples and means are 32-bit signed.
  assign abse      = e_q[32] ? 33'(-e_q) : e_q;

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    item_d     = item_q;
    res_d      = res_q;
    cnt_d      = cnt_q;
    mean_d     = mean_q;
    m2_d       = m2_q;
    dev_d      = dev_q;
    e_d        = e_q;
    prod_d     = prod_q;
    neg_d      = neg_q;
    stat_d     = stat_q;
    wait_div_d = wait_div_q;
    we         = 1'b0;
    waddr      = cell_addr;
    wdata      = {m2_q, cnt_q, mean_q};
    du_cmd     = '0;
    du_num     = '0;
    du_den     = '0;
    nmean      = '0;
    sum        = '0;
    in_if.ready = 1'b0;
    if (out_if.valid && out_if.ready) begin
      res_d = res_q;
    end
    unique case (state_q)
      S_CLR: begin
        we    = 1'b1;
        waddr = clr_q[AW-1:0];
        wdata = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == (AW+1)'(NUM_CELLS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          item_d  = in_if.data;
          state_d = S_RD;
        end
      end
      S_RD: begin
        stat_d = ST_OK;
        if (!in_range) begin
          res_d   = '{cell_count: '0, cell_mean: '0, cell_std: '0, status: ST_OK,
                      last_result: item_q.last_sample};
          state_d = S_OUT;
        end else begin
          state_d = S_LAT;
        end
      end
      S_LAT: begin
        m2_d   = rdata_q[M2W+CountW+DataW-1 -: M2W];
        cnt_d  = rdata_q[CountW+DataW-1 -: CountW];
        mean_d = rdata_q[DataW-1:0];
        if (item_q.func == FUNC_ADD) begin
          if (rdata_q[CountW+DataW-1 -: CountW] == CountMax) begin
            stat_d  = ST_CNT_SAT;
            state_d = S_DIV2;
          end else begin
            dev_d   = smp_ext - {rdata_q[DataW-1], rdata_q[DataW-1:0]};
            cnt_d   = rdata_q[CountW+DataW-1 -: CountW] + 1'b1;
            state_d = S_DIV1;
            wait_div_d = 1'b0;
          end
        end else begin
          state_d = S_DIV2;
        end
      end
      S_DIV1: begin
        if (!wait_div_q) begin
          du_cmd     = '{start: 1'b1, is_root: 1'b0};
          du_num     = 64'(absd) + 64'(cnt_q[CountW-1:1]);
          du_den     = 64'(cnt_q);
          neg_d      = dev_q[32];
          wait_div_d = 1'b1;
        end else if (du_done) begin
          nmean  = neg_q ? mean_ext - du_res[32:0] : mean_ext + du_res[32:0];
          mean_d = nmean[31:0];
          e_d    = smp_ext - nmean;
          wait_div_d = 1'b0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        prod_d  = {32'd0, absd[31:0]} * {32'd0, abse[31:0]};
        state_d = S_ACC;
      end
      S_ACC: begin
        sum = {1'b0, m2_q} + {1'b0, prod_q};
        if (sum[64]) begin
          m2_d   = '1;
          stat_d = ST_M2_SAT;
        end else begin
          m2_d = sum[63:0];
        end
        state_d = S_DIV2;
      end
      S_DIV2: begin
        if (cnt_q < CountW'(2)) begin
          dev_d   = '0;
          state_d = S_WB;
        end else if (!wait_div_q) begin
          du_cmd     = '{start: 1'b1, is_root: 1'b0};
          du_num     = m2_q;
          du_den     = 64'(cnt_q - 1'b1);
          wait_div_d = 1'b1;
        end else if (du_done) begin
          wait_div_d = 1'b0;
          state_d    = S_ROOT;
        end
      end
      S_ROOT: begin
        if (!wait_div_q) begin
          du_cmd     = '{start: 1'b1, is_root: 1'b1};
          du_num     = du_res;
          wait_div_d = 1'b1;
        end else if (du_done) begin
          wait_div_d = 1'b0;
          dev_d      = {1'b0, du_res[31:0]};
          state_d    = S_WB;
        end
      end
      S_WB: begin
        res_d = '{cell_count: cnt_q,
                  cell_mean: (cnt_q == '0) ? '0 : mean_q,
                  cell_std: dev_q[31:0],
                  status: stat_q,
                  last_result: item_q.last_sample};
        if (item_q.func == FUNC_CLEAR) begin
          we    = 1'b1;
          wdata = '0;
        end else if (item_q.func == FUNC_ADD && stat_q != ST_CNT_SAT) begin
          we = 1'b1;
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        state_d = S_WAITD;
      end
      S_WAITD: begin
        if (out_if.ready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_if.valid = (state_q == S_WAITD);
  assign out_if.data  = res_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[cell_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLR;
      clr_q      <= '0;
      wait_div_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      wait_div_q <= wait_div_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
    cnt_q  <= cnt_d;
    mean_q <= mean_d;
    m2_q   <= m2_d;
    dev_q  <= dev_d;
    e_q    <= e_d;
    prod_q <= prod_d;
    neg_q  <= neg_d;
    stat_q <= stat_d;
  end

`ifndef SYNTHESIS
  a_ready_idle_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.ready |-> !out_if.valid) else $error("input taken while result pending");
  a_accept_to_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |=> state_q == S_RD) else $error("accept lost");
  a_deliver_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.ready) |=> state_q == S_IDLE) else $error("result repeated");
  a_no_write_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == S_CLR || state_q == S_WB)) else $error("stray table write");
`endif
endmodule
